// File: rtl/shp_pkg.sv
// Shared constants, stage types and helper functions for the header parser.
package shp_pkg;

  localparam int HeaderBits = 20;
  localparam int SfMin = 7;
  localparam int SfMax = 12;
  localparam int RecipShift = 20;

  localparam logic [3:0] SF_RESET = 4'd7;
  localparam logic [0:0] REG_SF_INDEX = 1'b0;

  typedef struct packed {
    logic               vld;
    logic               hvalid;
    logic [7:0]         len;
    logic [2:0]         cr;
    logic               crc;
    logic [3:0]         sf;
    logic [3:0]         cw;
    logic signed [10:0] q;
    logic               pos;
    logic [9:0]         a;
    logic [17:0]        recip;
  } front_t;

  typedef struct packed {
    logic               vld;
    logic               hvalid;
    logic [7:0]         len;
    logic [2:0]         cr;
    logic               crc;
    logic [3:0]         sf;
    logic [3:0]         cw;
    logic signed [10:0] q;
    logic               pos;
    logic [6:0]         k;
  } div_t;

  typedef struct packed {
    logic               vld;
    logic               hvalid;
    logic [7:0]         len;
    logic [2:0]         cr;
    logic               crc;
    logic [3:0]         cw;
    logic signed [10:0] q;
    logic               pos;
    logic [9:0]         ksf;
    logic [9:0]         sym;
    logic [5:0]         negn;
  } mul_t;

  function automatic logic [4:0] header_checksum(input logic [11:0] t);
    logic [4:0] c;
    c[4] = t[11] ^ t[10] ^ t[9] ^ t[8];
    c[3] = t[11] ^ t[7] ^ t[6] ^ t[5] ^ t[0];
    c[2] = t[10] ^ t[7] ^ t[4] ^ t[3] ^ t[1];
    c[1] = t[9] ^ t[6] ^ t[4] ^ t[2] ^ t[1] ^ t[0];
    c[0] = t[8] ^ t[5] ^ t[3] ^ t[2] ^ t[1] ^ t[0];
    return c;
  endfunction

  // Reciprocal of the spreading factor scaled by two to the RecipShift, rounded up.
  function automatic logic [17:0] sf_recip(input logic [3:0] sf);
    logic [17:0] r;
    case (sf)
      4'd7:    r = 18'd149797;
      4'd8:    r = 18'd131072;
      4'd9:    r = 18'd116509;
      4'd10:   r = 18'd104858;
      4'd11:   r = 18'd95326;
      4'd12:   r = 18'd87382;
      default: r = 18'd149797;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/shp_regs.sv
// Configuration register file with the spreading factor and its clamped value.
module shp_regs
  import shp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [3:0]  sf_clamped
);

  logic [3:0] sf_reg;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_reg <= SF_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SF_INDEX) begin
      sf_reg <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SF_INDEX) begin
      prdata = {28'd0, sf_reg};
    end
  end

  always_comb begin
    if (sf_reg < 4'(SfMin)) begin
      sf_clamped = 4'(SfMin);
    end else if (sf_reg > 4'(SfMax)) begin
      sf_clamped = 4'(SfMax);
    end else begin
      sf_clamped = sf_reg;
    end
  end

endmodule

// File: rtl/shp_front.sv
// First stage: field split, checksum test and the uncoded bit count per item.
module shp_front
  import shp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [19:0] header_bits,
  input  logic [3:0]  sf,
  output front_t      st
);

  logic [7:0]         len;
  logic [2:0]         cr;
  logic               crc;
  logic [7:0]         check;
  logic               ok;
  logic [8:0]         lc;
  logic signed [10:0] q;

  assign len   = header_bits[19:12];
  assign cr    = header_bits[11:9];
  assign crc   = header_bits[8];
  assign check = header_bits[7:0];
  assign ok    = !crc || ({3'd0, header_checksum(header_bits[19:8])} == check);
  assign lc    = {1'b0, len} + {7'd0, crc, 1'b0};
  // The divide by four of the coded count is exact, so the quotient is built directly.
  assign q     = $signed({1'b0, lc, 1'b0}) + 11'sd7 - $signed({7'd0, sf});

  always_ff @(posedge clk) begin
    if (rst) begin
      st.vld <= 1'b0;
    end else begin
      st.vld <= start;
    end
    st.hvalid <= ok;
    st.len    <= len;
    st.cr     <= cr;
    st.crc    <= crc;
    st.sf     <= sf;
    st.cw     <= {1'b0, cr} + 4'd4;
    st.q      <= q;
    st.pos    <= !q[10] && (q != 11'sd0);
    st.a      <= 10'(q[9:0] + {6'd0, sf} - 10'd1);
    st.recip  <= sf_recip(sf);
  end

endmodule

// File: rtl/shp_div.sv
// Second stage: ceiling division by the spreading factor through a reciprocal multiply.
module shp_div
  import shp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  front_t in_st,
  output div_t   st
);

  logic [27:0] prod;

  assign prod = {18'd0, in_st.a} * {10'd0, in_st.recip};

  always_ff @(posedge clk) begin
    if (rst) begin
      st.vld <= 1'b0;
    end else begin
      st.vld <= in_st.vld;
    end
    st.hvalid <= in_st.hvalid;
    st.len    <= in_st.len;
    st.cr     <= in_st.cr;
    st.crc    <= in_st.crc;
    st.sf     <= in_st.sf;
    st.cw     <= in_st.cw;
    st.q      <= in_st.q;
    st.pos    <= in_st.pos;
    st.k      <= prod[RecipShift+6:RecipShift];
  end

endmodule

// File: rtl/shp_back.sv
// Third and fourth stages: block products, padding and the registered result.
module shp_back
  import shp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_t        in_st,
  output logic        done,
  output logic        header_valid,
  output logic [7:0]  payload_length,
  output logic [2:0]  coding_rate,
  output logic        crc_present,
  output logic [12:0] packet_length_bits,
  output logic [7:0]  pad_length,
  output logic [9:0]  packet_length_symbols
);

  mul_t        m;
  logic [2:0]  negq;
  logic [3:0]  diff;
  logic [12:0] total;
  logic [7:0]  padp;

  assign negq = 3'(-in_st.q);

  always_ff @(posedge clk) begin
    if (rst) begin
      m.vld <= 1'b0;
    end else begin
      m.vld <= in_st.vld;
    end
    m.hvalid <= in_st.hvalid;
    m.len    <= in_st.len;
    m.cr     <= in_st.cr;
    m.crc    <= in_st.crc;
    m.cw     <= in_st.cw;
    m.q      <= in_st.q;
    m.pos    <= in_st.pos;
    m.ksf    <= 10'({3'd0, in_st.k} * {6'd0, in_st.sf});
    m.sym    <= 10'({3'd0, in_st.k} * {6'd0, in_st.cw});
    m.negn   <= 6'({3'd0, negq} * {2'd0, in_st.cw});
  end

  assign diff  = 4'(m.ksf - m.q[9:0]);
  assign total = 13'({3'd0, m.ksf} * {9'd0, m.cw});
  assign padp  = 8'({4'd0, diff} * {4'd0, m.cw});

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (m.hvalid) begin
      header_valid   <= 1'b1;
      payload_length <= m.len;
      coding_rate    <= m.cr;
      crc_present    <= m.crc;
      if (m.pos) begin
        packet_length_bits    <= total;
        pad_length            <= padp;
        packet_length_symbols <= m.sym;
      end else begin
        packet_length_bits    <= '0;
        pad_length            <= {2'd0, m.negn};
        packet_length_symbols <= '0;
      end
    end else begin
      header_valid          <= 1'b0;
      payload_length        <= '0;
      coding_rate           <= '0;
      crc_present           <= 1'b0;
      packet_length_bits    <= '0;
      pad_length            <= '0;
      packet_length_symbols <= '0;
    end
  end

endmodule

// File: rtl/spread_spectrum_header_parser.sv
// The result strobe done follows the accept through the front, divide, block product and output registers.
// Throughput: one item per cycle; busy stays low, four register stages carry the work.
// The reciprocal multiply stage and the block product stage set the stage depth.
// Reset clears the stage valid bits and done, and sets the spreading factor to seven.
// The receiver cannot stall; each result is shown for exactly one cycle.
module spread_spectrum_header_parser
  import shp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [19:0] header_bits,
  output logic        done,
  output logic        header_valid,
  output logic [7:0]  payload_length,
  output logic [2:0]  coding_rate,
  output logic        crc_present,
  output logic [12:0] packet_length_bits,
  output logic [7:0]  pad_length,
  output logic [9:0]  packet_length_symbols,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] sf_clamped;
  front_t     front_st;
  div_t       div_st;

  assign busy = 1'b0;

  shp_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .sf_clamped (sf_clamped)
  );

  shp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start && !busy),
    .header_bits (header_bits),
    .sf          (sf_clamped),
    .st          (front_st)
  );

  shp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .in_st (front_st),
    .st    (div_st)
  );

  shp_back u_back (
    .clk                   (clk),
    .rst                   (rst),
    .in_st                 (div_st),
    .done                  (done),
    .header_valid          (header_valid),
    .payload_length        (payload_length),
    .coding_rate           (coding_rate),
    .crc_present           (crc_present),
    .packet_length_bits    (packet_length_bits),
    .pad_length            (pad_length),
    .packet_length_symbols (packet_length_symbols)
  );

endmodule
